// ===== hw/rtl/jpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_pkg
// Shared constants, types and reset tables of the joint PD torque controller.
// ----------------------------------------------------------------------------
package jpd_pkg;

    localparam int MAX_JOINTS     = 6;
    localparam int NUM_JOINTS_DEF = 6;

    localparam int JNT_W  = 3;
    localparam int ANG_W  = 21;
    localparam int ERR_W  = 22;
    localparam int GAIN_W = 16;
    localparam int LIM_W  = 15;
    localparam int TRQ_W  = 16;
    localparam int CFG_W  = 32;
    localparam int IDX_W  = 3;

    // Item kinds on the input stream
    localparam logic [1:0] OP_MEAS   = 2'd0;
    localparam logic [1:0] OP_TARGET = 2'd1;
    localparam logic [1:0] OP_TICK   = 2'd2;

    // Register index of the torque bound (gains sit at 0 .. MAX_JOINTS-1)
    localparam logic [IDX_W-1:0] CFG_LIMIT = 3'd6;

    // Angle constants, Q4.16
    localparam logic signed [ERR_W-1:0] PI_Q      = 22'sd205887;
    localparam logic signed [ERR_W-1:0] TWO_PI_Q  = 22'sd411775;
    localparam logic signed [ANG_W-1:0] HALF_PI_A = 21'sd102944;
    localparam logic signed [ANG_W-1:0] PI_A      = 21'sd205887;

    localparam logic [LIM_W-1:0] LIMIT_RESET = 15'd20480;

    // Gain reset: kp in the upper half, kd in the lower half, both Q8.8
    localparam logic [CFG_W-1:0] GAIN_RESET [MAX_JOINTS] = '{
        32'd2013272320, 32'd2013272320, 32'd2013272320,
        32'd754977792,  32'd503318784,  32'd335545856
    };

    typedef struct packed {
        logic start;
        logic ack;
    } t_calc_req;

    typedef struct packed {
        logic                    done;
        logic signed [TRQ_W-1:0] torque;
    } t_calc_rsp;

    // Home pose, used for a target entry that was never written
    function automatic logic signed [ANG_W-1:0] home_pose(input logic [JNT_W-1:0] j);
        logic signed [ANG_W-1:0] v;
        case (j)
            3'd1:    v = -HALF_PI_A;
            3'd2:    v = HALF_PI_A;
            3'd3:    v = -PI_A;
            3'd4:    v = -HALF_PI_A;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/joint_pd_torque_controller.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// joint_pd_torque_controller
// PD torque controller for up to six joints with angle-error wrapping.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s): tuser carries the item kind (measure, target, tick),
//   tdata the joint, angle, velocity and velocity flag. Measure and target
//   beats update the joint store; a tick beat, once every joint has been
//   measured, yields one torque beat per joint on the output stream (m),
//   in joint order, tlast on the final joint. Other ticks give nothing.
//   The user must write gains and the torque bound on the cfg channel only
//   while the block is idle; it is always ready and does not enforce this.
// Sequencing:
//   A target beat is written to the target RAM as it is accepted; a measure
//   beat does a read-modify-write of the position/velocity RAM. A tick steps
//   each joint through address, read and the torque unit, which takes one wrap
//   step per 2*pi of error. Input ready drops while a measure or tick beat works.
// Reset and stall:
//   Reset restores gains, bound, home targets and clears all seen flags;
//   no RAM clearing pass is needed. A stalled output holds its beat in the
//   output register; the torque unit waits and the next beat is accepted
//   as soon as the tick work is finished.
// ----------------------------------------------------------------------------
module joint_pd_torque_controller #(
    parameter int NUM_JOINTS = jpd_pkg::NUM_JOINTS_DEF
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    // slave stream
    input  wire                                  i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire  [47:0]                          i_s_tdata,   // joint[2:0], angle[23:3],
                                                              // velocity[44:24],
                                                              // has_velocity[45], zero pad
    input  wire  [1:0]                           i_s_tuser,   // opcode[1:0]
    // master stream
    output logic                                 o_m_tvalid,
    input  wire                                  i_m_tready,
    output logic [23:0]                          o_m_tdata,   // out_joint[2:0],
                                                              // torque[18:3], zero pad
    output logic                                 o_m_tlast,   // last
    // configuration writes
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [jpd_pkg::IDX_W-1:0]            i_cfg_index,
    input  wire  [jpd_pkg::CFG_W-1:0]            i_cfg_data
);
    import jpd_pkg::*;

    localparam int AW = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;
    localparam logic [JNT_W-1:0] LAST_J = JNT_W'(NUM_JOINTS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MADR  = 3'd1;
    localparam logic [2:0] S_MWR   = 3'd2;
    localparam logic [2:0] S_TADR  = 3'd3;
    localparam logic [2:0] S_TRD   = 3'd4;
    localparam logic [2:0] S_TCALC = 3'd5;

    // Input beat fields
    logic [1:0]               w_op;
    logic [JNT_W-1:0]         w_joint;
    logic signed [ANG_W-1:0]  w_angle;
    logic signed [ANG_W-1:0]  w_velo;
    logic                     w_hasv;

    assign w_op    = i_s_tuser;
    assign w_joint = i_s_tdata[2:0];
    assign w_angle = i_s_tdata[23:3];
    assign w_velo  = i_s_tdata[44:24];
    assign w_hasv  = i_s_tdata[45];

    logic [2:0]               r_state, n_state;
    logic [AW-1:0]            r_idx,   n_idx;
    logic signed [ANG_W-1:0]  r_mang,  n_mang;
    logic signed [ANG_W-1:0]  r_mvel,  n_mvel;
    logic                     r_mhasv, n_mhasv;
    logic [NUM_JOINTS-1:0]    r_seen,  n_seen;
    logic [NUM_JOINTS-1:0]    r_tvld,  n_tvld;

    logic [CFG_W-1:0]         r_gains [MAX_JOINTS];
    logic [LIM_W-1:0]         r_limit;

    logic                     r_ovalid;
    logic [JNT_W-1:0]         r_ojoint;
    logic signed [TRQ_W-1:0]  r_otorque;
    logic                     r_olast;

    logic                     w_accept;
    logic                     w_joint_ok;
    logic                     w_seen_all;
    logic                     w_out_free;
    logic                     w_load;
    logic                     w_tgt_we;
    logic                     w_pv_we;
    logic [2*ANG_W-1:0]       w_pv_wdata;
    logic [2*ANG_W-1:0]       w_pv_rdata;
    logic [ANG_W-1:0]         w_tgt_rdata;
    logic signed [ANG_W-1:0]  w_old_vel;
    logic signed [ANG_W-1:0]  w_tgt;
    logic [CFG_W-1:0]         w_gain;
    logic [JNT_W-1:0]         w_idx_j;
    t_calc_req                w_req;
    t_calc_rsp                w_rsp;

    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_s_tvalid & o_s_tready;
    assign w_joint_ok  = (w_joint < JNT_W'(NUM_JOINTS));
    assign w_seen_all  = &r_seen;
    assign w_idx_j     = JNT_W'(r_idx);
    assign w_gain      = r_gains[w_idx_j];

    // Position/velocity store: velocity in the upper half
    assign w_pv_we    = (r_state == S_MWR);
    assign w_old_vel  = r_seen[r_idx] ? $signed(w_pv_rdata[2*ANG_W-1:ANG_W]) : '0;
    assign w_pv_wdata = {(r_mhasv ? r_mvel : w_old_vel), r_mang};

    jpd_ram #(
        .WIDTH (2 * ANG_W),
        .DEPTH (NUM_JOINTS)
    ) u_pv_ram (
        .i_clk   (i_clk),
        .i_we    (w_pv_we),
        .i_waddr (r_idx),
        .i_wdata (w_pv_wdata),
        .i_raddr (r_idx),
        .o_rdata (w_pv_rdata)
    );

    // Target store: written straight from the input beat
    assign w_tgt_we = w_accept && (w_op == OP_TARGET) && w_joint_ok;

    jpd_ram #(
        .WIDTH (ANG_W),
        .DEPTH (NUM_JOINTS)
    ) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (w_tgt_we),
        .i_waddr (w_joint[AW-1:0]),
        .i_wdata (w_angle),
        .i_raddr (r_idx),
        .o_rdata (w_tgt_rdata)
    );

    // Unwritten target entries read as the home pose
    assign w_tgt = r_tvld[r_idx] ? $signed(w_tgt_rdata) : home_pose(w_idx_j);

    assign w_out_free = !r_ovalid || i_m_tready;
    assign w_load     = (r_state == S_TCALC) && w_rsp.done && w_out_free;
    assign w_req.start = (r_state == S_TRD);
    assign w_req.ack   = w_load;

    jpd_calc u_calc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_tgt   (w_tgt),
        .i_pos   ($signed(w_pv_rdata[ANG_W-1:0])),
        .i_vel   ($signed(w_pv_rdata[2*ANG_W-1:ANG_W])),
        .i_kp    (w_gain[CFG_W-1:GAIN_W]),
        .i_kd    (w_gain[GAIN_W-1:0]),
        .i_limit (r_limit),
        .o_rsp   (w_rsp)
    );

    // Sequencer: measure read-modify-write, target write, tick over joints
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_mang  = r_mang;
        n_mvel  = r_mvel;
        n_mhasv = r_mhasv;
        n_seen  = r_seen;
        n_tvld  = r_tvld;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_op)
                        OP_MEAS: begin
                            if (w_joint_ok) begin
                                n_idx   = w_joint[AW-1:0];
                                n_mang  = w_angle;
                                n_mvel  = w_velo;
                                n_mhasv = w_hasv;
                                n_state = S_MADR;
                            end
                        end
                        OP_TARGET: begin
                            if (w_joint_ok) begin
                                n_tvld = r_tvld | (NUM_JOINTS'(1) << w_joint[AW-1:0]);
                            end
                        end
                        OP_TICK: begin
                            if (w_seen_all) begin
                                n_idx   = '0;
                                n_state = S_TADR;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_MADR: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                n_seen  = r_seen | (NUM_JOINTS'(1) << r_idx);
                n_state = S_IDLE;
            end
            S_TADR: begin
                n_state = S_TRD;
            end
            S_TRD: begin
                n_state = S_TCALC;
            end
            S_TCALC: begin
                if (w_load) begin
                    if (w_idx_j == LAST_J) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_TADR;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_seen  <= '0;
            r_tvld  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_seen  <= n_seen;
            r_tvld  <= n_tvld;
        end
        r_mang  <= n_mang;
        r_mvel  <= n_mvel;
        r_mhasv <= n_mhasv;
    end

    // Configuration registers; indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_JOINTS; k++) begin
                r_gains[k] <= GAIN_RESET[k];
            end
            r_limit <= LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index < CFG_LIMIT) begin
                r_gains[i_cfg_index] <= i_cfg_data;
            end else if (i_cfg_index == CFG_LIMIT) begin
                r_limit <= i_cfg_data[LIM_W-1:0];
            end
        end
    end

    // Output register: load a torque beat, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (w_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
        if (w_load) begin
            r_ojoint  <= w_idx_j;
            r_otorque <= w_rsp.torque;
            r_olast   <= (w_idx_j == LAST_J);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {5'd0, r_otorque, r_ojoint};
    assign o_m_tlast  = r_olast;

    // Checks
    logic signed [TRQ_W-1:0] w_lim16;
    assign w_lim16 = $signed({1'b0, r_limit});

    a_load_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> ($past(r_state) == S_TCALC))
        else $error("torque beat appeared outside a tick");

    a_tick_all_seen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TADR) |-> w_seen_all)
        else $error("tick running before every joint was measured");

    a_torque_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> ((r_otorque <= w_lim16) && (r_otorque >= -w_lim16)))
        else $error("torque beat beyond the bound");

    a_last_joint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_olast) |-> (r_ojoint == LAST_J))
        else $error("tlast on a joint other than the final one");

endmodule
`default_nettype wire

// ===== hw/rtl/jpd_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire                                  i_clk,
    input  wire                                  i_we,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]                     i_wdata,
    input  wire  [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== hw/rtl/jpd_calc.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// jpd_calc
// Torque unit for one joint: wrap the angle error, form kp*err - kd*vel,
// round to Q8.8 and clamp. Holds the torque until acknowledged.
// ----------------------------------------------------------------------------
module jpd_calc (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire  jpd_pkg::t_calc_req             i_req,
    input  wire  signed [jpd_pkg::ANG_W-1:0]     i_tgt,
    input  wire  signed [jpd_pkg::ANG_W-1:0]     i_pos,
    input  wire  signed [jpd_pkg::ANG_W-1:0]     i_vel,
    input  wire  [jpd_pkg::GAIN_W-1:0]           i_kp,
    input  wire  [jpd_pkg::GAIN_W-1:0]           i_kd,
    input  wire  [jpd_pkg::LIM_W-1:0]            i_limit,
    output jpd_pkg::t_calc_rsp                   o_rsp
);
    import jpd_pkg::*;

    localparam logic [2:0] C_IDLE = 3'd0;
    localparam logic [2:0] C_WRAP = 3'd1;
    localparam logic [2:0] C_MULP = 3'd2;
    localparam logic [2:0] C_MULD = 3'd3;
    localparam logic [2:0] C_SAT  = 3'd4;
    localparam logic [2:0] C_DONE = 3'd5;

    logic [2:0]                r_state, n_state;
    logic signed [ERR_W-1:0]   r_err,   n_err;
    logic signed [ANG_W-1:0]   r_vel,   n_vel;
    logic signed [38:0]        r_prod,  n_prod;
    logic signed [39:0]        r_acc,   n_acc;
    logic signed [TRQ_W-1:0]   r_torque, n_torque;

    logic signed [38:0]        w_pterm;
    logic signed [37:0]        w_dterm;
    logic signed [39:0]        w_rnd;
    logic signed [23:0]        w_t;
    logic signed [23:0]        w_lim;

    // Products and rounding
    assign w_pterm = $signed({1'b0, i_kp}) * r_err;
    assign w_dterm = $signed({1'b0, i_kd}) * r_vel;
    assign w_rnd   = r_acc + 40'sd32768;
    assign w_t     = w_rnd[39:16];
    assign w_lim   = $signed({9'd0, i_limit});

    // Sequence one joint through wrap, multiply and clamp
    always_comb begin
        n_state  = r_state;
        n_err    = r_err;
        n_vel    = r_vel;
        n_prod   = r_prod;
        n_acc    = r_acc;
        n_torque = r_torque;
        case (r_state)
            C_IDLE: begin
                if (i_req.start) begin
                    n_err   = ERR_W'(i_tgt) - ERR_W'(i_pos);
                    n_vel   = i_vel;
                    n_state = C_WRAP;
                end
            end
            C_WRAP: begin
                // one wrap step per cycle until the error lies in [-pi, pi]
                if (r_err > PI_Q) begin
                    n_err = r_err - TWO_PI_Q;
                end else if (r_err < -PI_Q) begin
                    n_err = r_err + TWO_PI_Q;
                end else begin
                    n_state = C_MULP;
                end
            end
            C_MULP: begin
                n_prod  = w_pterm;
                n_state = C_MULD;
            end
            C_MULD: begin
                n_acc   = 40'(r_prod) - 40'(w_dterm);
                n_state = C_SAT;
            end
            C_SAT: begin
                if (w_t > w_lim) begin
                    n_torque = TRQ_W'(w_lim);
                end else if (w_t < -w_lim) begin
                    n_torque = TRQ_W'(-w_lim);
                end else begin
                    n_torque = TRQ_W'(w_t);
                end
                n_state = C_DONE;
            end
            C_DONE: begin
                if (i_req.ack) begin
                    n_state = C_IDLE;
                end
            end
            default: begin
                n_state = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_err    <= n_err;
        r_vel    <= n_vel;
        r_prod   <= n_prod;
        r_acc    <= n_acc;
        r_torque <= n_torque;
    end

    assign o_rsp.done   = (r_state == C_DONE);
    assign o_rsp.torque = r_torque;

endmodule
`default_nettype wire

// ===== bench/torque_check_pkg.sv =====
// ----------------------------------------------------------------------------
// torque_check_pkg
// Expected-torque model and result checker for the joint PD controller bench:
// mirrors the joint store, gains and bound, and queues the torque beats that
// each tick must produce.
// ----------------------------------------------------------------------------
package torque_check_pkg;

    import jpd_pkg::*;

    // One beat of the input stream, field by field
    typedef struct packed {
        logic [1:0]              op;
        logic [JNT_W-1:0]        jnt;
        logic signed [ANG_W-1:0] ang;
        logic signed [ANG_W-1:0] vel;
        logic                    has_vel;
    } t_joint_item;

    // One beat of the torque stream
    typedef struct packed {
        logic [JNT_W-1:0]        jnt;
        logic signed [TRQ_W-1:0] trq;
        logic                    is_last;
    } t_torque_beat;

    class torque_scoreboard;
        logic signed [ANG_W-1:0] pos_q [MAX_JOINTS];
        logic signed [ANG_W-1:0] vel_q [MAX_JOINTS];
        logic signed [ANG_W-1:0] tgt_q [MAX_JOINTS];
        logic [CFG_W-1:0]        gain_q [MAX_JOINTS];
        logic [LIM_W-1:0]        torque_bound;
        logic [MAX_JOINTS-1:0]   seen_q;
        int                      num_joints;
        int                      n_errors;
        t_torque_beat            torque_q [$];

        // Start from the post-reset state: home pose targets, default gains
        function new(int nj);
            num_joints = nj;
            n_errors   = 0;
            for (int j = 0; j < MAX_JOINTS; j++) begin
                pos_q[j]  = '0;
                vel_q[j]  = '0;
                gain_q[j] = GAIN_RESET[j];
            end
            tgt_q[0] = '0;
            tgt_q[1] = -HALF_PI_A;
            tgt_q[2] = HALF_PI_A;
            tgt_q[3] = -PI_A;
            tgt_q[4] = -HALF_PI_A;
            tgt_q[5] = '0;
            torque_bound = LIMIT_RESET;
            seen_q       = '0;
        endfunction

        function void flag(string msg);
            n_errors++;
            if (n_errors <= 10) begin
                $display("%s", msg);
            end
        endfunction

        // Mirror a register write; indexes past the bound are dropped
        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            if (idx == CFG_LIMIT) begin
                torque_bound = data[LIM_W-1:0];
            end else if (idx < MAX_JOINTS) begin
                gain_q[idx] = data;
            end
        endfunction

        // Update the joint store and queue the torques a tick produces
        function void note_item(t_joint_item it);
            longint                kp;
            longint                kd;
            longint                err;
            longint                acc;
            longint                trq;
            longint                lim;
            logic [MAX_JOINTS-1:0] all_mask;
            t_torque_beat          beat;
            all_mask = MAX_JOINTS'((1 << num_joints) - 1);
            case (it.op)
                OP_MEAS: begin
                    if (it.jnt < num_joints) begin
                        pos_q[it.jnt] = it.ang;
                        if (it.has_vel) begin
                            vel_q[it.jnt] = it.vel;
                        end
                        seen_q[it.jnt] = 1'b1;
                    end
                end
                OP_TARGET: begin
                    if (it.jnt < num_joints) begin
                        tgt_q[it.jnt] = it.ang;
                    end
                end
                OP_TICK: begin
                    if ((seen_q & all_mask) == all_mask) begin
                        for (int j = 0; j < num_joints; j++) begin
                            kp  = longint'(gain_q[j][31:16]);
                            kd  = longint'(gain_q[j][15:0]);
                            lim = longint'(torque_bound);
                            // Wrap the angle error into [-pi, pi]
                            err = longint'(tgt_q[j]) - longint'(pos_q[j]);
                            while (err > longint'(PI_Q)) begin
                                err -= longint'(TWO_PI_Q);
                            end
                            while (err < -longint'(PI_Q)) begin
                                err += longint'(TWO_PI_Q);
                            end
                            // Q.24 product, round half up to Q8.8, then clamp
                            acc = kp * err - kd * longint'(vel_q[j]);
                            trq = (acc + 64'sd32768) >>> 16;
                            if (trq > lim) begin
                                trq = lim;
                            end
                            if (trq < -lim) begin
                                trq = -lim;
                            end
                            beat.jnt     = JNT_W'(j);
                            beat.trq     = trq[TRQ_W-1:0];
                            beat.is_last = (j == num_joints - 1);
                            torque_q.push_back(beat);
                        end
                    end
                end
                default: begin
                end
            endcase
        endfunction

        // Compare one received torque beat with the oldest expected one
        function void check_torque(t_torque_beat got);
            t_torque_beat want;
            if (torque_q.size() == 0) begin
                flag($sformatf("unexpected torque beat: joint %0d torque %0d last %0d",
                               got.jnt, got.trq, got.is_last));
            end else begin
                want = torque_q.pop_front();
                if (got.jnt !== want.jnt) begin
                    flag($sformatf("joint mismatch: expected %0d got %0d",
                                   want.jnt, got.jnt));
                end
                if (got.trq !== want.trq) begin
                    flag($sformatf("torque mismatch on joint %0d: expected %0d got %0d",
                                   want.jnt, want.trq, got.trq));
                end
                if (got.is_last !== want.is_last) begin
                    flag($sformatf("last mismatch on joint %0d: expected %0d got %0d",
                                   want.jnt, want.is_last, got.is_last));
                end
            end
        endfunction

        function int pending();
            return torque_q.size();
        endfunction

        function void close();
            if (torque_q.size() != 0) begin
                flag($sformatf("%0d torque beats never arrived", torque_q.size()));
            end
        endfunction
    endclass

endpackage

// ===== bench/joint_pd_torque_controller_tb.sv =====
// ----------------------------------------------------------------------------
// joint_pd_torque_controller_tb
// Drives measure, target and tick beats into the PD controller under several
// gain and bound settings, with random gaps and output stalls, and checks
// every torque beat against a cycle-free model of the controller.
// ----------------------------------------------------------------------------
module joint_pd_torque_controller_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import jpd_pkg::*;
    import torque_check_pkg::*;

    localparam int               NJ           = NUM_JOINTS_DEF;
    localparam int               CYCLE_LIMIT  = 400000;
    localparam int               DRAIN_CYCLES = 200;
    localparam logic [1:0]       OP_UNUSED    = 2'd3;
    localparam logic [IDX_W-1:0] CFG_UNUSED   = 3'd7;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [47:0]       i_s_tdata;
    logic [1:0]        i_s_tuser;
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [23:0]       o_m_tdata;
    logic              o_m_tlast;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]  i_cfg_data;

    torque_scoreboard  sb;
    bit                idle_on;
    int                cycle_cnt;
    logic [CFG_W-1:0]  gain_set [MAX_JOINTS];

    joint_pd_torque_controller #(
        .NUM_JOINTS (NJ)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_joint_item mk_item(logic [1:0] op, int jnt, int ang, int vel,
                                            int has_vel);
        t_joint_item it;
        it.op      = op;
        it.jnt     = JNT_W'(jnt);
        it.ang     = ANG_W'(ang);
        it.vel     = ANG_W'(vel);
        it.has_vel = 1'(has_vel);
        return it;
    endfunction

    // Half full range, half small values so torques often stay unclamped
    function automatic logic signed [ANG_W-1:0] rand_q416();
        if ($urandom_range(0, 1) == 1) begin
            return ANG_W'($urandom);
        end
        return ANG_W'(int'($urandom_range(0, 16383)) - 8192);
    endfunction

    // Send one beat; valid stays high across back-to-back beats
    task automatic send_item(t_joint_item it);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, it.has_vel, it.vel, it.ang, it.jnt};
        i_s_tuser  <= it.op;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(it);
    endtask

    // Hold off input until every torque is back and the block has gone quiet
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Program all gains and the bound, plus one write to the unused index
    task automatic load_setting(logic [CFG_W-1:0] gains [MAX_JOINTS],
                                logic [LIM_W-1:0] bound);
        settle();
        for (int j = 0; j < MAX_JOINTS; j++) begin
            write_reg(IDX_W'(j), gains[j]);
        end
        write_reg(CFG_LIMIT, CFG_W'(bound));
        write_reg(CFG_UNUSED, $urandom);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed beats; noise beats do not count toward n
    task automatic run_random(int n);
        int          cnt;
        int          pick;
        t_joint_item it;
        cnt = 0;
        while (cnt < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                it = mk_item(OP_MEAS, $urandom_range(0, NJ - 1), rand_q416(), rand_q416(),
                             $urandom_range(0, 1));
                cnt++;
            end else if (pick < 65) begin
                it = mk_item(OP_TARGET, $urandom_range(0, NJ - 1), rand_q416(), rand_q416(),
                             $urandom_range(0, 1));
                cnt++;
            end else if (pick < 90) begin
                it = mk_item(OP_TICK, $urandom_range(0, 7), rand_q416(), rand_q416(),
                             $urandom_range(0, 1));
                cnt++;
            end else if (pick < 95) begin
                it = mk_item(OP_UNUSED, $urandom_range(0, 7), rand_q416(), rand_q416(),
                             $urandom_range(0, 1));
            end else begin
                it = mk_item($urandom_range(0, 1) ? OP_MEAS : OP_TARGET,
                             $urandom_range(NJ, 7), rand_q416(), rand_q416(),
                             $urandom_range(0, 1));
            end
            send_item(it);
        end
    endtask

    // Accept torque beats, stalling in random bursts while idling is on
    initial begin : result_sink
        int           stall_left;
        t_torque_beat got;
        stall_left = 0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got.jnt     = o_m_tdata[2:0];
                got.trq     = o_m_tdata[18:3];
                got.is_last = o_m_tlast;
                sb.check_torque(got);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_m_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // Cut off a hung run
    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("joint_pd_torque_controller_tb failed");
        $finish;
    end

    initial begin : stimulus
        sb      = new(NJ);
        idle_on = 1'b1;
        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= OP_MEAS;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: no torques until every joint is measured, with reset gains
        send_item(mk_item(OP_TICK, 0, 0, 0, 0));
        send_item(mk_item(OP_MEAS, 0, 1048575, -1048576, 1));
        send_item(mk_item(OP_MEAS, 1, -1048576, 1048575, 1));
        send_item(mk_item(OP_MEAS, 2, 0, 1048575, 0));
        send_item(mk_item(OP_MEAS, 3, 1, -1, 1));
        send_item(mk_item(OP_MEAS, 4, -1, 777, 0));
        // Out-of-range joints must not mark the last joint seen
        send_item(mk_item(OP_MEAS, 6, 1000, 1000, 1));
        send_item(mk_item(OP_MEAS, 7, -1000, -1000, 1));
        send_item(mk_item(OP_TARGET, 7, 5000, 0, 0));
        send_item(mk_item(OP_UNUSED, 5, 12345, 678, 1));
        send_item(mk_item(OP_TICK, 5, 0, 0, 0));
        // Error of exactly -pi on joint 5 stays unwrapped
        send_item(mk_item(OP_MEAS, 5, 205887, 0, 1));
        send_item(mk_item(OP_TICK, 0, 0, 0, 0));
        // Largest errors, several wrap steps, and exactly +pi on joint 4
        send_item(mk_item(OP_TARGET, 0, -1048576, 0, 0));
        send_item(mk_item(OP_TARGET, 1, 1048575, 0, 0));
        send_item(mk_item(OP_TARGET, 3, 205889, 0, 0));
        send_item(mk_item(OP_TARGET, 4, 205886, 0, 0));
        // Measurement without velocity keeps the stored one
        send_item(mk_item(OP_MEAS, 2, 300, -1048576, 0));
        send_item(mk_item(OP_TICK, 0, 0, 0, 0));
        send_item(mk_item(OP_UNUSED, 0, 0, 0, 0));
        send_item(mk_item(OP_TARGET, 6, 100, 0, 0));
        send_item(mk_item(OP_TICK, 7, -1, -1, 1));

        // Moderate random gains and bound
        for (int j = 0; j < MAX_JOINTS; j++) begin
            gain_set[j] = {16'($urandom_range(0, 2047)), 16'($urandom_range(0, 1023))};
        end
        load_setting(gain_set, LIM_W'($urandom_range(256, 32767)));
        run_random(70);

        // Largest gains and bound
        for (int j = 0; j < MAX_JOINTS; j++) begin
            gain_set[j] = '1;
        end
        load_setting(gain_set, '1);
        run_random(50);

        // Zero bound with arbitrary gains, then zero gains
        for (int j = 0; j < MAX_JOINTS; j++) begin
            gain_set[j] = $urandom;
        end
        load_setting(gain_set, '0);
        run_random(25);
        for (int j = 0; j < MAX_JOINTS; j++) begin
            gain_set[j] = '0;
        end
        load_setting(gain_set, LIM_W'($urandom_range(0, 32767)));
        run_random(20);

        // Default gains, random bound; the final stretch runs with no gaps
        gain_set = GAIN_RESET;
        load_setting(gain_set, LIM_W'($urandom_range(1024, 32767)));
        run_random(50);
        idle_on = 1'b0;
        run_random(50);

        settle();
        sb.close();
        if (sb.n_errors == 0) begin
            $display("joint_pd_torque_controller_tb passed");
        end else begin
            $display("joint_pd_torque_controller_tb failed");
        end
        $finish;
    end

endmodule
